[rtl/core/smll_pkg.sv]
// Shared constants, types and a helper function for the smooth L1 loss unit.
package smll_pkg;

   localparam int DATA_W = 32;
   localparam int BETA_W = 31;
   localparam int CNT_W  = 32;
   localparam int MODE_W = 2;
   localparam int ADDR_W = 2;
   localparam int MAG_W  = DATA_W + 1;
   localparam int PROD_W = 2 * DATA_W;
   localparam int DIV1_STAGES = DATA_W;
   localparam int DIV2_STAGES = MAG_W;
   localparam int LAT = 3 + DIV1_STAGES + 1 + DIV2_STAGES + 1;

   localparam logic [ADDR_W-1:0] REG_BETA  = 2'd0;
   localparam logic [ADDR_W-1:0] REG_COUNT = 2'd1;
   localparam logic [ADDR_W-1:0] REG_MODE  = 2'd2;

   localparam logic [MODE_W-1:0] MODE_MEAN = 2'd2;
   localparam logic REQ_BACKWARD = 1'b1;

   localparam logic [BETA_W-1:0] BETA_RESET  = 31'd65536;
   localparam logic [CNT_W-1:0]  COUNT_RESET = 32'd1;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } clamp_type;

   function automatic clamp_type clamp_word(input logic neg, input logic [MAG_W-1:0] mag);
      clamp_type r;
      logic [MAG_W-1:0] lim;
      lim = {2'b00, {(DATA_W-1){1'b1}}} + MAG_W'(neg);
      r.sat = mag > lim;
      if (r.sat) begin
         r.value = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r.value = neg ? DATA_W'(-mag) : mag[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/core/smooth_l1_loss_unit_core.sv]
// Smooth L1 loss element unit: pipelined forward loss and backward gradient.
//
// Usage: items enter on the req_ stream (tdata holds input, target and
// upstream gradient; tuser is the forward/backward selector) and one result
// transaction leaves on the rsp_ stream per input transaction, in order.
// Registers (beta, element count, reduction mode) are written through the
// csr_ port while the unit is empty.
// Throughput is one transaction per cycle while rsp_tready does not stall
// the output. The pipeline has three front stages (difference, magnitudes,
// multiplier), a 32-stage restoring divider by beta, a select stage, a
// 33-stage restoring divider by the element count, and the saturating
// output register. The two divider chains set the depth.
// When the receiver deasserts rsp_tready while a result is waiting, the
// whole pipeline holds, bubbles included, and req_tready falls until the
// result is taken.
// A synchronous reset empties the pipeline and restores the registers to
// beta 1.0, count 1 and no reduction.
module smooth_l1_loss_unit_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [smll_pkg::ADDR_W-1:0]       csr_addr,
   input  logic [smll_pkg::CNT_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // input_value, target_value, upstream_grad
   input  logic [3*smll_pkg::DATA_W-1:0]     req_tdata,
   // req_type
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // loss_value, grad_input, grad_target
   output logic [3*smll_pkg::DATA_W-1:0]     rsp_tdata,
   // saturated
   output logic                              rsp_tuser
);
   import smll_pkg::*;

   logic [BETA_W-1:0] beta_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [LAT-1:0]    vld_ff;
   logic              adv;

   logic               a_bwd_ff;
   logic [MAG_W-1:0]   a_d_ff;
   logic [DATA_W-1:0]  a_g_ff;

   logic               b_bwd_ff, b_neg_ff, b_quad_ff;
   logic [MAG_W-1:0]   b_ad_ff;
   logic [DATA_W-1:0]  b_ag_ff;
   logic [MAG_W-1:0]   b_ad_in;
   logic [DATA_W-1:0]  b_ag_in;

   logic               c_bwd_ff, c_neg_ff, c_quad_ff;
   logic [PROD_W-1:0]  c_prod_ff;
   logic [MAG_W-1:0]   c_lin_ff;
   logic [DATA_W-1:0]  c_div_ff;
   logic [MAG_W:0]     c_lin_in;

   logic               d1_bwd_ff  [DIV1_STAGES];
   logic               d1_neg_ff  [DIV1_STAGES];
   logic               d1_quad_ff [DIV1_STAGES];
   logic [MAG_W-1:0]   d1_lin_ff  [DIV1_STAGES];
   logic [DATA_W-1:0]  d1_div_ff  [DIV1_STAGES];
   logic [DATA_W-1:0]  d1_rem_ff  [DIV1_STAGES];
   logic [DATA_W-1:0]  d1_quo_ff  [DIV1_STAGES];

   logic               m_bwd_ff, m_neg_ff;
   logic [MAG_W-1:0]   m_val_ff;

   logic               d2_bwd_ff [DIV2_STAGES];
   logic               d2_neg_ff [DIV2_STAGES];
   logic [CNT_W-1:0]   d2_rem_ff [DIV2_STAGES];
   logic [MAG_W-1:0]   d2_quo_ff [DIV2_STAGES];
   logic [CNT_W-1:0]   cnt_div;

   logic [3*DATA_W-1:0] out_data_ff;
   logic                out_sat_ff;
   logic [MAG_W-1:0]    f_m;
   logic                f_nz, f_neg;
   clamp_type           f_loss, f_gi, f_gt;

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sat_ff;

   assign cnt_div = (mode_ff == MODE_MEAN && count_ff != '0) ? count_ff : CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff  <= BETA_RESET;
         count_ff <= COUNT_RESET;
         mode_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_BETA:  beta_ff  <= csr_wdata[BETA_W-1:0];
            REG_COUNT: count_ff <= csr_wdata;
            REG_MODE:  mode_ff  <= csr_wdata[MODE_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_comb begin
      b_ad_in  = a_d_ff[MAG_W-1] ? MAG_W'(-a_d_ff) : a_d_ff;
      b_ag_in  = a_g_ff[DATA_W-1] ? DATA_W'(-a_g_ff) : a_g_ff;
      c_lin_in = {b_ad_ff, 1'b0} - {3'b000, beta_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_bwd_ff <= req_tuser == REQ_BACKWARD;
         a_d_ff   <= {req_tdata[DATA_W-1], req_tdata[DATA_W-1:0]}
                   - {req_tdata[2*DATA_W-1], req_tdata[2*DATA_W-1:DATA_W]};
         a_g_ff   <= req_tdata[3*DATA_W-1:2*DATA_W];

         b_bwd_ff  <= a_bwd_ff;
         b_neg_ff  <= a_d_ff[MAG_W-1] ^ a_g_ff[DATA_W-1];
         b_ad_ff   <= b_ad_in;
         b_ag_ff   <= b_ag_in;
         b_quad_ff <= b_ad_in < {2'b00, beta_ff};

         c_bwd_ff  <= b_bwd_ff;
         c_neg_ff  <= b_neg_ff;
         c_quad_ff <= b_quad_ff;
         c_prod_ff <= PROD_W'(b_ad_ff[DATA_W-1:0])
                    * PROD_W'(b_bwd_ff ? b_ag_ff : b_ad_ff[DATA_W-1:0]);
         c_lin_ff  <= b_bwd_ff ? {1'b0, b_ag_ff} : c_lin_in[MAG_W:1];
         c_div_ff  <= b_bwd_ff ? {1'b0, beta_ff} : {beta_ff, 1'b0};

         for (int k = 0; k < DIV1_STAGES; k++) begin
            logic [DATA_W:0]   t;
            logic [DATA_W-1:0] rem, quo, dv;
            rem = (k == 0) ? c_prod_ff[PROD_W-1:DATA_W] : d1_rem_ff[k-1];
            quo = (k == 0) ? c_prod_ff[DATA_W-1:0]      : d1_quo_ff[k-1];
            dv  = (k == 0) ? c_div_ff                    : d1_div_ff[k-1];
            t   = {rem, quo[DATA_W-1]};
            if (t >= {1'b0, dv}) begin
               t = t - {1'b0, dv};
               d1_quo_ff[k] <= {quo[DATA_W-2:0], 1'b1};
            end else begin
               d1_quo_ff[k] <= {quo[DATA_W-2:0], 1'b0};
            end
            d1_rem_ff[k]  <= t[DATA_W-1:0];
            d1_div_ff[k]  <= dv;
            d1_bwd_ff[k]  <= (k == 0) ? c_bwd_ff  : d1_bwd_ff[k-1];
            d1_neg_ff[k]  <= (k == 0) ? c_neg_ff  : d1_neg_ff[k-1];
            d1_quad_ff[k] <= (k == 0) ? c_quad_ff : d1_quad_ff[k-1];
            d1_lin_ff[k]  <= (k == 0) ? c_lin_ff  : d1_lin_ff[k-1];
         end

         m_bwd_ff <= d1_bwd_ff[DIV1_STAGES-1];
         m_neg_ff <= d1_neg_ff[DIV1_STAGES-1];
         m_val_ff <= d1_quad_ff[DIV1_STAGES-1] ? {1'b0, d1_quo_ff[DIV1_STAGES-1]}
                                               : d1_lin_ff[DIV1_STAGES-1];

         for (int k = 0; k < DIV2_STAGES; k++) begin
            logic [CNT_W:0]   t;
            logic [CNT_W-1:0] rem;
            logic [MAG_W-1:0] quo;
            rem = (k == 0) ? '0       : d2_rem_ff[k-1];
            quo = (k == 0) ? m_val_ff : d2_quo_ff[k-1];
            t   = {rem, quo[MAG_W-1]};
            if (t >= {1'b0, cnt_div}) begin
               t = t - {1'b0, cnt_div};
               d2_quo_ff[k] <= {quo[MAG_W-2:0], 1'b1};
            end else begin
               d2_quo_ff[k] <= {quo[MAG_W-2:0], 1'b0};
            end
            d2_rem_ff[k] <= t[CNT_W-1:0];
            d2_bwd_ff[k] <= (k == 0) ? m_bwd_ff : d2_bwd_ff[k-1];
            d2_neg_ff[k] <= (k == 0) ? m_neg_ff : d2_neg_ff[k-1];
         end

         if (d2_bwd_ff[DIV2_STAGES-1]) begin
            out_data_ff <= {f_gt.value, f_gi.value, {DATA_W{1'b0}}};
            out_sat_ff  <= f_gi.sat || f_gt.sat;
         end else begin
            out_data_ff <= {{(2*DATA_W){1'b0}}, f_loss.value};
            out_sat_ff  <= f_loss.sat;
         end
      end
   end

   always_comb begin
      f_m    = d2_quo_ff[DIV2_STAGES-1];
      f_nz   = f_m != '0;
      f_neg  = d2_neg_ff[DIV2_STAGES-1] && f_nz;
      f_loss = clamp_word(1'b0, f_m);
      f_gi   = clamp_word(f_neg, f_m);
      f_gt   = clamp_word(!f_neg && f_nz, f_m);
   end

endmodule
